// File: design/kdd_pkg.sv
package kdd_pkg;

   localparam int unsigned KEY_WIDTH   = 16;
   localparam int unsigned TICK_WIDTH  = 16;
   localparam int unsigned DEB_WIDTH   = 10;
   localparam int unsigned CODE_WIDTH  = 8;
   localparam int unsigned CSR_IDX_WIDTH  = 2;
   localparam int unsigned CSR_DATA_WIDTH = 10;

   localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

   localparam logic [DEB_WIDTH-1:0]  DEBOUNCE_RESET = 10'd20;
   localparam logic [CODE_WIDTH-1:0] STOP_RESET     = 8'd32;
   localparam logic [CODE_WIDTH-1:0] RST_RESET      = 8'd33;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STOP_CODE  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RESET_CODE = 2'd2;

   // Key codes
   localparam logic [CODE_WIDTH-1:0] CODE_NONE = 8'h00;
   localparam logic [CODE_WIDTH-1:0] CODE_BASE = 8'h10;
   localparam logic [CODE_WIDTH-1:0] CODE_STAR = 8'h1a;
   localparam logic [CODE_WIDTH-1:0] CODE_ZERO = 8'h10;
   localparam logic [CODE_WIDTH-1:0] CODE_HASH = 8'h1b;

   typedef enum logic [1:0] {
      PHASE_RELEASE = 2'b01,
      PHASE_RESCAN  = 2'b10
   } phase_type;

   typedef struct packed {
      logic                 key_down;
      logic                 press_event;
      logic [KEY_WIDTH-1:0] held_value;
   } deb_status_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] key_bits;
      logic                 start_button;
      logic                 stop_button;
      logic                 reset_button;
   } scan_type;

   typedef struct packed {
      logic                  key_down;
      logic                  press_event;
      logic [CODE_WIDTH-1:0] key_code;
      logic                  start_flag;
   } result_type;

endpackage

// File: design/keypad_debounce_decode_top.sv
// Channel  Direction  Payload (low bit first)
// req      in         key_bits[15:0], start_button, stop_button, reset_button
// rsp      out        key_down, press_event, key_code[7:0], start_flag
// csr      in         write-only: 0 debounce_ticks, 1 stop_code, 2 reset_code
//
// One scan beat is accepted per cycle while req_tready is high; its result
// beat is presented on the next cycle from the result register.
// The debounce/decode state advances only on an accepted req beat.
// A stalled rsp beat holds req_tready low only while the result register
// is full and rsp_tready is low; otherwise req keeps flowing.
// Synchronous reset loads the csr defaults (20, 32, 33) and clears all state but the result data.
module keypad_debounce_decode_top (
   input  logic        clock,
   input  logic        reset,
   // req beat
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // key_bits[15:0], start, stop, reset, zero pad
   // rsp beat
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // key_down, press_event, key_code[7:0], start_flag, pad
   // csr write port
   input  logic        csr_we,
   input  logic [kdd_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [kdd_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import kdd_pkg::*;

   logic [DEB_WIDTH-1:0]  debounce_ff;
   logic [CODE_WIDTH-1:0] stop_code_ff;
   logic [CODE_WIDTH-1:0] reset_code_ff;

   scan_type       scan;
   deb_status_type status;
   result_type     result;
   logic           step;

   logic           rsp_valid_ff;
   result_type     rsp_data_ff;

   // Unpack the req beat
   assign scan.key_bits     = req_tdata[15:0];
   assign scan.start_button = req_tdata[16];
   assign scan.stop_button  = req_tdata[17];
   assign scan.reset_button = req_tdata[18];

   // Accept whenever the result register is empty or draining this cycle
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign step       = req_tvalid & req_tready;

   // Configuration registers, write-only
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         stop_code_ff  <= STOP_RESET;
         reset_code_ff <= RST_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE:   debounce_ff   <= csr_wdata[DEB_WIDTH-1:0];
            CSR_STOP_CODE:  stop_code_ff  <= csr_wdata[CODE_WIDTH-1:0];
            CSR_RESET_CODE: reset_code_ff <= csr_wdata[CODE_WIDTH-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   kdd_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .key_bits       (scan.key_bits),
      .debounce_ticks (debounce_ff),
      .status         (status)
   );

   kdd_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .status       (status),
      .start_button (scan.start_button),
      .stop_button  (scan.stop_button),
      .reset_button (scan.reset_button),
      .stop_code    (stop_code_ff),
      .reset_code   (reset_code_ff),
      .result       (result)
   );

   // Result register: load on accept, clear valid once the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0,
                        rsp_data_ff.start_flag,
                        rsp_data_ff.key_code,
                        rsp_data_ff.press_event,
                        rsp_data_ff.key_down};

endmodule

// File: design/kdd_debounce.sv
module kdd_debounce (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [kdd_pkg::KEY_WIDTH-1:0]     key_bits,
   input  logic [kdd_pkg::DEB_WIDTH-1:0]     debounce_ticks,
   output kdd_pkg::deb_status_type           status
);
   import kdd_pkg::*;

   phase_type             phase_ff, phase_in;
   logic                  pressed_ff, pressed_in;
   logic                  before_ff;
   logic [KEY_WIDTH-1:0]  prev_ff, prev_in;
   logic [KEY_WIDTH-1:0]  held_ff, held_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;
   logic [TICK_WIDTH-1:0] tick_inc;
   logic                  expired;

   assign tick_inc = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + 1'b1;
   assign expired  = tick_inc > {{(TICK_WIDTH-DEB_WIDTH){1'b0}}, debounce_ticks};

   always_comb begin
      phase_in   = phase_ff;
      pressed_in = pressed_ff;
      prev_in    = prev_ff;
      held_in    = held_ff;
      tick_in    = tick_inc;
      case (phase_ff)
         PHASE_RESCAN: begin
            if (key_bits == '0) begin
               phase_in = PHASE_RELEASE;
               prev_in  = '0;
            end else if (key_bits != prev_ff) begin
               prev_in = key_bits;
               tick_in = '0;
            end else if (expired) begin
               pressed_in = 1'b1;
               phase_in   = PHASE_RELEASE;
               held_in    = key_bits;
            end
         end
         default: begin
            if (key_bits == prev_ff) begin
               tick_in = '0;
            end else if (expired) begin
               pressed_in = 1'b0;
               phase_in   = PHASE_RESCAN;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_RELEASE;
         pressed_ff <= 1'b0;
         before_ff  <= 1'b0;
         prev_ff    <= '0;
         held_ff    <= '0;
         tick_ff    <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         pressed_ff <= pressed_in;
         before_ff  <= pressed_in;
         prev_ff    <= prev_in;
         held_ff    <= held_in;
         tick_ff    <= tick_in;
      end
   end

   assign status.key_down    = pressed_in;
   assign status.press_event = pressed_in & ~before_ff;
   assign status.held_value  = held_in;

endmodule

// File: design/kdd_decode.sv
module kdd_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  kdd_pkg::deb_status_type        status,
   input  logic                           start_button,
   input  logic                           stop_button,
   input  logic                           reset_button,
   input  logic [kdd_pkg::CODE_WIDTH-1:0] stop_code,
   input  logic [kdd_pkg::CODE_WIDTH-1:0] reset_code,
   output kdd_pkg::result_type            result
);
   import kdd_pkg::*;

   logic [CODE_WIDTH-1:0] last_ff, last_in;
   logic [CODE_WIDTH-1:0] code;
   logic [CODE_WIDTH-1:0] key_code;
   logic                  key_ok;
   logic                  sflag;
   logic [3:0]            rows;
   logic [2:0]            cols;

   assign rows = status.held_value[3:0];
   assign cols = status.held_value[6:4];

   // Map one-hot row/column pair to a key code
   always_comb begin
      key_ok   = 1'b1;
      key_code = CODE_NONE;
      case ({rows, cols})
         7'b0001_001: key_code = CODE_BASE + 8'd1;
         7'b0001_010: key_code = CODE_BASE + 8'd2;
         7'b0001_100: key_code = CODE_BASE + 8'd3;
         7'b0010_001: key_code = CODE_BASE + 8'd4;
         7'b0010_010: key_code = CODE_BASE + 8'd5;
         7'b0010_100: key_code = CODE_BASE + 8'd6;
         7'b0100_001: key_code = CODE_BASE + 8'd7;
         7'b0100_010: key_code = CODE_BASE + 8'd8;
         7'b0100_100: key_code = CODE_BASE + 8'd9;
         7'b1000_001: key_code = CODE_STAR;
         7'b1000_010: key_code = CODE_ZERO;
         7'b1000_100: key_code = CODE_HASH;
         default:     key_ok   = 1'b0;
      endcase
   end

   always_comb begin
      last_in = last_ff;
      sflag   = 1'b0;
      if (rows != '0 && cols != '0) begin
         if (key_ok) begin
            last_in = key_code;
            code    = key_code;
         end else begin
            code = CODE_NONE;
         end
      end else begin
         // Button fallback, start has priority and keeps the last code
         if (start_button) begin
            sflag = 1'b1;
         end else if (stop_button) begin
            last_in = stop_code;
         end else if (reset_button) begin
            last_in = reset_code;
         end else begin
            last_in = CODE_NONE;
         end
         code = last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= CODE_NONE;
      end else if (step) begin
         last_ff <= last_in;
      end
   end

   assign result.key_down    = status.key_down;
   assign result.press_event = status.press_event;
   assign result.key_code    = code;
   assign result.start_flag  = sflag;

endmodule
